@@ design/easing_interpolator_top_macros.svh @@
// Assertion macros of the easing interpolator top level.
`ifndef EASING_INTERPOLATOR_TOP_MACROS_SVH
`define EASING_INTERPOLATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define EASE_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define EASE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ease_pkg.sv @@
// Types, constants and curve codes of the easing interpolator.
`timescale 1ns / 1ps

package ease_pkg;

   localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

   // Divider geometry: a 48-bit dividend, a 16-bit divisor and a quotient
   // known to fit in 33 bits, resolved three bits per stage.
   localparam int NUM_W      = 48;
   localparam int DIV_W      = 16;
   localparam int QUO_W      = 33;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   localparam longint Q16_ONE     = 64'sd65536;
   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint Q30_HALF_PI = 64'sd1686629713;

   // Taylor series of the sine: divisor (2n)(2n+1) of term n.
   localparam int TAYLOR_TERMS = 10;
   localparam longint TAYLOR_DIV [1:10] = '{
      64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
      64'sd156, 64'sd210, 64'sd272, 64'sd342, 64'sd420};

   typedef enum logic [2:0] {
      OP_LINEAR       = 3'd0,
      OP_QUARTER_SINE = 3'd1,
      OP_FULL_SINE    = 3'd2,
      OP_INV_COSINE   = 3'd3,
      OP_SMOOTH       = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] start_value;
      logic signed [31:0] end_value;
      logic [15:0]        position;
      logic [15:0]        duration;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               done_res;
   } rsp_type;

   // Per-item context that travels alongside the arithmetic.
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] start;
      logic signed [31:0] endv;
      logic signed [32:0] diff;
      logic               done;
      logic               neg;
   } ctx_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] acc;
   } div_state_type;

endpackage

@@ design/ease_div.sv @@
// Pipelined restoring divider, three quotient bits per stage.
`timescale 1ns / 1ps

module ease_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [ease_pkg::NUM_W-1:0]   in_num,
   input  logic [ease_pkg::DIV_W-1:0]   in_div,
   input  ease_pkg::ctx_type            in_ctx,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [ease_pkg::QUO_W-1:0]   out_quo,
   output ease_pkg::ctx_type            out_ctx
);

   localparam int NS = ease_pkg::DIV_STAGES;
   localparam int DW = ease_pkg::DIV_W;
   localparam int QW = ease_pkg::QUO_W;

   logic                v_ff   [NS];
   logic [DW-1:0]       rem_ff [NS];
   logic [QW-1:0]       acc_ff [NS];
   logic [DW-1:0]       div_ff [NS];
   ease_pkg::ctx_type   ctx_ff [NS];
   logic [NS:0]         rdy;

   function automatic ease_pkg::div_state_type div_steps(
      ease_pkg::div_state_type st, logic [DW-1:0] dv);
      ease_pkg::div_state_type r;
      logic [DW:0] t;
      logic        qbit;
      r = st;
      for (int k = 0; k < ease_pkg::DIV_STEPS; k++) begin
         t = {r.rem, r.acc[QW-1]};
         qbit = (t >= {1'b0, dv});
         r.rem = qbit ? DW'(t - {1'b0, dv}) : t[DW-1:0];
         r.acc = {r.acc[QW-2:0], qbit};
      end
      return r;
   endfunction

   assign rdy[NS] = out_ready;
   assign in_ready = rdy[0];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic                    src_v;
      ease_pkg::div_state_type src_st;
      ease_pkg::div_state_type nxt_st;
      logic [DW-1:0]           src_div;
      ease_pkg::ctx_type       src_ctx;

      if (s == 0) begin : g_first
         assign src_v      = in_valid;
         assign src_st.rem = DW'(in_num[ease_pkg::NUM_W-1:QW]);
         assign src_st.acc = in_num[QW-1:0];
         assign src_div    = in_div;
         assign src_ctx    = in_ctx;
      end else begin : g_rest
         assign src_v      = v_ff[s-1];
         assign src_st.rem = rem_ff[s-1];
         assign src_st.acc = acc_ff[s-1];
         assign src_div    = div_ff[s-1];
         assign src_ctx    = ctx_ff[s-1];
      end

      assign rdy[s]  = !v_ff[s] || rdy[s+1];
      assign nxt_st  = div_steps(src_st, src_div);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            rem_ff[s] <= nxt_st.rem;
            acc_ff[s] <= nxt_st.acc;
            div_ff[s] <= src_div;
            ctx_ff[s] <= src_ctx;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_quo   = acc_ff[NS-1];
   assign out_ctx   = ctx_ff[NS-1];

endmodule

@@ design/easing_interpolator_top.sv @@
// Top level of the easing interpolator: tween curves over Q16.16 values.
`timescale 1ns / 1ps
//
// Usage: each item on the req_ channel carries a curve op, a start value, an
// end value, a position and a duration; the block returns exactly one item
// on the rsp_ channel with the interpolated value and a done flag. Items are
// independent, so the block is fully pipelined and takes one item per
// cycle while the result side does not stall. Both channels use valid and
// stall; an item moves when valid is high and stall is low. The pipeline
// is the shared divider, eleven stages of three quotient bits each, plus
// an input stage, a multiply stage, a numerator stage and five stages for
// the sine lookup, the curve multiply and the final add and saturation.
// The sine table is a registered ROM read at one address per cycle unless
// the pipeline stalls. A stall on the result side holds the output register;
// bubbles inside the pipeline still close up, so new items are taken until
// every stage is full, and only then is req_stall raised. Synchronous reset
// empties every stage; the block holds no other state, so no clearing pass
// is needed.
//
module easing_interpolator_top #(
   parameter int unsigned SINE_TABLE_DEPTH = ease_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ease_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ease_pkg::rsp_type rsp_data
);

`include "easing_interpolator_top_macros.svh"

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PH_W  = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int MUL_W = 51;

   // Quarter-wave sine table, built at elaboration from a Taylor series.
   typedef logic [16:0] rom_table_type [SINE_TABLE_DEPTH + 1];

   function automatic rom_table_type build_rom();
      rom_table_type tbl;
      longint        x;
      longint        term;
      longint        sum;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x = (longint'(i) * ease_pkg::Q30_HALF_PI) / SINE_TABLE_DEPTH;
         term = x;
         sum = x;
         for (int n = 1; n <= ease_pkg::TAYLOR_TERMS; n++) begin
            term = (term * x) / ease_pkg::Q30_ONE;
            term = (term * x) / ease_pkg::Q30_ONE;
            term = -term / ease_pkg::TAYLOR_DIV[n];
            sum += term;
         end
         if (sum < 0) begin
            sum = 0;
         end
         sum = (sum + 64'sd8192) >>> 14;
         if (sum > ease_pkg::Q16_ONE) begin
            sum = ease_pkg::Q16_ONE;
         end
         tbl[i] = 17'(sum);
      end
      return tbl;
   endfunction

   localparam rom_table_type ROM_TABLE = build_rom();

   // Stage A: input register, difference and early-exit decision.
   logic              v_a_ff;
   ease_pkg::ctx_type ctx_a_ff, ctx_a_in;
   logic [15:0]       pos_a_ff, dur_a_ff;
   logic              rdy_a;

   // Stage B: product register.
   logic                    v_b_ff;
   ease_pkg::ctx_type       ctx_b_ff;
   logic signed [MUL_W-1:0] prod_b_ff, prod_b_in;
   logic [15:0]             div_b_ff, div_b_in;
   logic                    rdy_b;
   logic signed [33:0]      mul_a;
   logic signed [16:0]      mul_b;

   // Stage C: dividend magnitude and sign.
   logic                           v_c_ff;
   ease_pkg::ctx_type              ctx_c_ff, ctx_c_in;
   logic [ease_pkg::NUM_W-1:0]     num_c_ff, num_c_in;
   logic [15:0]                    div_c_ff;
   logic                           rdy_c;
   logic signed [MUL_W-1:0]        numer;

   // Divider outputs.
   logic                       div_in_ready;
   logic                       div_out_valid;
   logic [ease_pkg::QUO_W-1:0] div_quo;
   ease_pkg::ctx_type          div_ctx;

   // Stage D: signed quotient and table address.
   logic               v_d_ff;
   ease_pkg::ctx_type  ctx_d_ff;
   logic signed [33:0] qs_d_ff, qs_d_in;
   logic [IDX_W-1:0]   idx_d_ff, idx_d_in;
   logic               rneg_d_ff, rneg_d_in;
   logic               rdy_d;
   logic [PH_W-1:0]    phase;
   logic [1:0]         quad;
   logic [IDX_W-1:0]   off;

   // Stage E: table read.
   logic               v_e_ff;
   ease_pkg::ctx_type  ctx_e_ff;
   logic signed [33:0] qs_e_ff;
   logic [16:0]        rom_e_ff;
   logic               rneg_e_ff;
   logic               rdy_e;

   // Stage F: Q16 curve factor.
   logic               v_f_ff;
   ease_pkg::ctx_type  ctx_f_ff;
   logic signed [33:0] qs_f_ff;
   logic signed [17:0] f_f_ff, f_f_in;
   logic signed [17:0] rom_s;
   logic               rdy_f;

   // Stage G: curve product.
   logic                    v_g_ff;
   ease_pkg::ctx_type       ctx_g_ff;
   logic signed [33:0]      qs_g_ff;
   logic signed [MUL_W-1:0] mul_g_ff;
   logic                    rdy_g;

   // Stage H: output register.
   logic                    v_h_ff;
   ease_pkg::rsp_type       rsp_h_ff, rsp_h_in;
   logic                    rdy_h;
   logic signed [MUL_W-1:0] biased;
   logic signed [34:0]      scaled;
   logic signed [35:0]      sum_h;

   // Stall chain: a stage loads when it is empty or its successor moves.
   assign rdy_h     = !v_h_ff || !rsp_stall;
   assign rdy_g     = !v_g_ff || rdy_h;
   assign rdy_f     = !v_f_ff || rdy_g;
   assign rdy_e     = !v_e_ff || rdy_f;
   assign rdy_d     = !v_d_ff || rdy_e;
   assign rdy_c     = !v_c_ff || div_in_ready;
   assign rdy_b     = !v_b_ff || rdy_c;
   assign rdy_a     = !v_a_ff || rdy_b;
   assign req_stall = !rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_e_ff <= 1'b0;
         v_f_ff <= 1'b0;
         v_g_ff <= 1'b0;
         v_h_ff <= 1'b0;
      end else begin
         if (rdy_a) v_a_ff <= req_valid;
         if (rdy_b) v_b_ff <= v_a_ff;
         if (rdy_c) v_c_ff <= v_b_ff;
         if (rdy_d) v_d_ff <= div_out_valid;
         if (rdy_e) v_e_ff <= v_d_ff;
         if (rdy_f) v_f_ff <= v_e_ff;
         if (rdy_g) v_g_ff <= v_f_ff;
         if (rdy_h) v_h_ff <= v_g_ff;
      end
   end

   // Stage A. The end value is returned as is when the easing has run out,
   // when the smoothing factor is too small, and for codes with no curve.
   always_comb begin
      ctx_a_in.op    = req_data.op;
      ctx_a_in.start = req_data.start_value;
      ctx_a_in.endv  = req_data.end_value;
      ctx_a_in.diff  = 33'(req_data.end_value) - 33'(req_data.start_value);
      ctx_a_in.neg   = 1'b0;
      if (req_data.op == ease_pkg::OP_SMOOTH) begin
         ctx_a_in.done = (req_data.position <= 16'd1);
      end else if (req_data.op <= ease_pkg::OP_INV_COSINE) begin
         ctx_a_in.done = (req_data.position >= req_data.duration);
      end else begin
         ctx_a_in.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         ctx_a_ff <= ctx_a_in;
         pos_a_ff <= req_data.position;
         dur_a_ff <= req_data.duration;
      end
   end

   // Stage B. One multiplier serves every op: the linear numerator, the
   // weighted start of smoothing and the scaled phase of the sine curves.
   always_comb begin
      mul_b    = signed'({1'b0, pos_a_ff});
      div_b_in = dur_a_ff;
      case (ctx_a_ff.op)
         ease_pkg::OP_LINEAR: begin
            mul_a = 34'(ctx_a_ff.diff);
         end
         ease_pkg::OP_SMOOTH: begin
            mul_a    = 34'(ctx_a_ff.start);
            mul_b    = signed'({1'b0, pos_a_ff}) - 17'sd1;
            div_b_in = pos_a_ff;
         end
         ease_pkg::OP_FULL_SINE: begin
            mul_a = 34'(4 * SINE_TABLE_DEPTH);
         end
         default: begin
            mul_a = 34'(SINE_TABLE_DEPTH);
         end
      endcase
      prod_b_in = MUL_W'(mul_a) * MUL_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         ctx_b_ff  <= ctx_a_ff;
         prod_b_ff <= prod_b_in;
         div_b_ff  <= div_b_in;
      end
   end

   // Stage C. The divider works on magnitudes; the sign rides along so the
   // quotient can be truncated toward zero.
   always_comb begin
      numer = prod_b_ff;
      if (ctx_b_ff.op == ease_pkg::OP_SMOOTH) begin
         numer = prod_b_ff + MUL_W'(ctx_b_ff.endv);
      end
      ctx_c_in     = ctx_b_ff;
      ctx_c_in.neg = numer[MUL_W-1];
      num_c_in     = numer[MUL_W-1] ? ease_pkg::NUM_W'(-numer)
                                    : ease_pkg::NUM_W'(numer);
   end

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         ctx_c_ff <= ctx_c_in;
         num_c_ff <= num_c_in;
         div_c_ff <= div_b_ff;
      end
   end

   ease_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_c_ff),
      .in_ready  (div_in_ready),
      .in_num    (num_c_ff),
      .in_div    (div_c_ff),
      .in_ctx    (ctx_c_ff),
      .out_valid (div_out_valid),
      .out_ready (rdy_d),
      .out_quo   (div_quo),
      .out_ctx   (div_ctx)
   );

   // Stage D. The phase splits into a quadrant and an offset; odd quadrants
   // read the table mirrored, the second half of the wave is negated.
   always_comb begin
      qs_d_in = div_ctx.neg ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
      phase   = div_quo[PH_W-1:0];
      if (phase >= PH_W'(3 * SINE_TABLE_DEPTH)) begin
         quad = 2'd3;
         off  = IDX_W'(phase - PH_W'(3 * SINE_TABLE_DEPTH));
      end else if (phase >= PH_W'(2 * SINE_TABLE_DEPTH)) begin
         quad = 2'd2;
         off  = IDX_W'(phase - PH_W'(2 * SINE_TABLE_DEPTH));
      end else if (phase >= PH_W'(SINE_TABLE_DEPTH)) begin
         quad = 2'd1;
         off  = IDX_W'(phase - PH_W'(SINE_TABLE_DEPTH));
      end else begin
         quad = 2'd0;
         off  = IDX_W'(phase);
      end
      rneg_d_in = quad[1];
      idx_d_in  = quad[0] ? IDX_W'(SINE_TABLE_DEPTH) - off : off;
      if (div_ctx.op == ease_pkg::OP_INV_COSINE) begin
         rneg_d_in = 1'b0;
         idx_d_in  = IDX_W'(SINE_TABLE_DEPTH) - IDX_W'(phase);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_d) begin
         ctx_d_ff  <= div_ctx;
         qs_d_ff   <= qs_d_in;
         idx_d_ff  <= idx_d_in;
         rneg_d_ff <= rneg_d_in;
      end
   end

   // Stage E: registered table read.
   always_ff @(posedge clock) begin
      if (rdy_e) begin
         ctx_e_ff  <= ctx_d_ff;
         qs_e_ff   <= qs_d_ff;
         rneg_e_ff <= rneg_d_ff;
         rom_e_ff  <= ROM_TABLE[idx_d_ff];
      end
   end

   // Stage F: ease-in uses one minus the cosine, the others the signed sine.
   always_comb begin
      rom_s = signed'(18'(rom_e_ff));
      if (ctx_e_ff.op == ease_pkg::OP_INV_COSINE) begin
         f_f_in = 18'(ease_pkg::Q16_ONE) - rom_s;
      end else begin
         f_f_in = rneg_e_ff ? -rom_s : rom_s;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_f) begin
         ctx_f_ff <= ctx_e_ff;
         qs_f_ff  <= qs_e_ff;
         f_f_ff   <= f_f_in;
      end
   end

   // Stage G: difference times curve factor.
   always_ff @(posedge clock) begin
      if (rdy_g) begin
         ctx_g_ff <= ctx_f_ff;
         qs_g_ff  <= qs_f_ff;
         mul_g_ff <= MUL_W'(ctx_f_ff.diff) * MUL_W'(f_f_ff);
      end
   end

   // Stage H: scale back from Q16 toward zero, add the start, saturate.
   always_comb begin
      biased = mul_g_ff;
      if (mul_g_ff[MUL_W-1]) begin
         biased = mul_g_ff + MUL_W'(ease_pkg::Q16_ONE - 1);
      end
      scaled = biased[MUL_W-1:16];
      case (ctx_g_ff.op)
         ease_pkg::OP_LINEAR: sum_h = 36'(ctx_g_ff.start) + 36'(qs_g_ff);
         ease_pkg::OP_SMOOTH: sum_h = 36'(qs_g_ff);
         default:             sum_h = 36'(ctx_g_ff.start) + 36'(scaled);
      endcase
      if (sum_h > 36'sd2147483647) begin
         rsp_h_in.value = 32'sh7fffffff;
      end else if (sum_h < -36'sd2147483648) begin
         rsp_h_in.value = 32'sh80000000;
      end else begin
         rsp_h_in.value = sum_h[31:0];
      end
      rsp_h_in.done_res = ctx_g_ff.done;
      if (ctx_g_ff.done) begin
         rsp_h_in.value = ctx_g_ff.endv;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_h) begin
         rsp_h_ff <= rsp_h_in;
      end
   end

   assign rsp_valid = v_h_ff;
   assign rsp_data  = rsp_h_ff;

   `EASE_ASSERT_IMPL(stall_only_when_full, req_stall, v_a_ff, "input stalled with empty stage")
   `EASE_ASSERT_NEXT(done_returns_end, v_g_ff && ctx_g_ff.done && rdy_h,
      rsp_data.value == $past(ctx_g_ff.endv) && rsp_data.done_res, "done item lost end value")
   `EASE_ASSERT_IMPL(quarter_sine_positive,
      v_d_ff && ctx_d_ff.op == ease_pkg::OP_QUARTER_SINE && !ctx_d_ff.done,
      !rneg_d_ff, "quarter sine phase left first quadrant")
   `EASE_ASSERT_IMPL(rom_index_in_range,
      v_d_ff && !ctx_d_ff.done && (ctx_d_ff.op == ease_pkg::OP_QUARTER_SINE ||
      ctx_d_ff.op == ease_pkg::OP_FULL_SINE || ctx_d_ff.op == ease_pkg::OP_INV_COSINE),
      idx_d_ff <= IDX_W'(SINE_TABLE_DEPTH), "sine table index out of range")

endmodule
